// ===== rtl/core/smcc_pkg.sv =====
// Package for the slice map consistency checker.
// Holds field widths, action and status codes and the default table depth.
// No dependencies.
package smcc_pkg;

    localparam int NUM_PARTITIONS_DEF = 1024;

    localparam int ACTION_W = 2;
    localparam int PART_W   = 16;
    localparam int COUNT_W  = 32;
    localparam int STATUS_W = 3;
    localparam int MISM_W   = 10;

    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SLICE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_LOADED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FREE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_COUNTED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_UNALLOC = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_REPORT  = 3'd5;

endpackage

// ===== rtl/core/slice_map_consistency_check.sv =====
// Slice map consistency checker, top level.
// Claim and slice count memories with a read-modify-write and sweep sequencer.
// Depends on smcc_pkg.
//
// A load, a free slice or an out-of-range slice gives its result in the cycle after the
// transfer; a counted slice gives it after the read-modify-write state, a finish item gives
// its report after the sweep and drain states. Throughput: loads and slices that need no
// counter access every cycle while busy is low; a counted slice ties up the block for one
// read and one write of the count memory, a finish item for its whole sweep. Results cannot
// be stalled. After reset, busy stays high while both memories are cleared.
module slice_map_consistency_check #(
    parameter int NUM_PARTITIONS = smcc_pkg::NUM_PARTITIONS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [smcc_pkg::ACTION_W-1:0]  i_action,
    input  logic [smcc_pkg::PART_W-1:0]    i_partition,
    input  logic [smcc_pkg::COUNT_W-1:0]   i_claimed_count,
    output logic                           o_done,
    output logic [smcc_pkg::STATUS_W-1:0]  o_status,
    output logic [smcc_pkg::PART_W-1:0]    o_owner,
    output logic [smcc_pkg::MISM_W-1:0]    o_mismatch_count,
    output logic [smcc_pkg::MISM_W-1:0]    o_first_mismatch,
    output logic                           o_all_valid
);

    // Address width of the two memories.
    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam logic [smcc_pkg::PART_W:0] PART_LIMIT = (smcc_pkg::PART_W + 1)'(NUM_PARTITIONS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTITIONS - 1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;  // clearing pass after reset
    localparam logic [2:0] S_IDLE  = 3'd1;  // ready for a transfer
    localparam logic [2:0] S_RMW   = 3'd2;  // slice count read data back, write it
    localparam logic [2:0] S_SWEEP = 3'd3;  // report sweep, one partition per cycle
    localparam logic [2:0] S_DRAIN = 3'd4;  // last compare and report

    localparam int unsigned COUNT_W = smcc_pkg::COUNT_W;
    localparam int unsigned MISM_W  = smcc_pkg::MISM_W;

    // The two memories: claimed counts and counted slices per partition.
    logic [COUNT_W-1:0] claim_mem  [NUM_PARTITIONS];
    logic [COUNT_W-1:0] actual_mem [NUM_PARTITIONS];

    logic [2:0]                    r_state;
    logic [IDX_W-1:0]              r_addr;
    logic [smcc_pkg::PART_W-1:0]   r_part;
    logic                          r_valid_flag;
    logic [COUNT_W-1:0]            r_claim_rd;
    logic [COUNT_W-1:0]            r_actual_rd;
    logic                          r_pend;
    logic [IDX_W-1:0]              r_pend_idx;
    logic [MISM_W-1:0]             r_mism;
    logic [MISM_W-1:0]             r_first;

    logic                          r_done;
    logic [smcc_pkg::STATUS_W-1:0] r_status;
    logic [smcc_pkg::PART_W-1:0]   r_owner;
    logic [MISM_W-1:0]             r_mism_out;
    logic [MISM_W-1:0]             r_first_out;
    logic                          r_all_valid;

    logic [MISM_W-1:0]             n_mism;
    logic [MISM_W-1:0]             n_first;

    logic                          w_accept;
    logic                          w_in_range;
    logic                          w_nonzero;
    logic [IDX_W-1:0]              w_in_idx;
    logic                          w_hit;
    logic                          w_claim_we;
    logic [IDX_W-1:0]              w_claim_waddr;
    logic [COUNT_W-1:0]            w_claim_wdata;
    logic                          w_actual_we;
    logic [IDX_W-1:0]              w_actual_waddr;
    logic [COUNT_W-1:0]            w_actual_wdata;
    logic [IDX_W-1:0]              w_rd_addr;
    logic [COUNT_W-1:0]            w_count_inc;
    logic                          w_unalloc;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Owner and load index checks on the incoming item.
    assign w_in_range = ({1'b0, i_partition} < PART_LIMIT);
    assign w_nonzero  = (i_partition != '0);
    assign w_in_idx   = i_partition[IDX_W-1:0];

    // Read-modify-write path of a counted slice. The read data was captured at the transfer.
    assign w_unalloc   = (r_claim_rd == '0);
    assign w_count_inc = (r_actual_rd == '1) ? r_actual_rd : r_actual_rd + COUNT_W'(1);

    // Sweep compare stage: one partition's claim and count each cycle.
    assign w_hit = r_pend && (r_claim_rd != '0) && (r_claim_rd != r_actual_rd);

    always_comb begin
        n_mism  = r_mism;
        n_first = r_first;
        if (w_hit) begin
            if (r_mism == '0) begin
                n_first = MISM_W'(r_pend_idx);
            end
            if (r_mism != '1) begin
                n_mism = r_mism + MISM_W'(1);
            end
        end
    end

    // Memory port control. Loads and the clearing pass write the claim memory; counted
    // slices, the sweep and the clearing pass write the count memory.
    always_comb begin
        w_claim_we    = 1'b0;
        w_claim_waddr = w_in_idx;
        w_claim_wdata = i_claimed_count;
        if (r_state == S_CLEAR) begin
            w_claim_we    = 1'b1;
            w_claim_waddr = r_addr;
            w_claim_wdata = '0;
        end else if (w_accept && i_action == smcc_pkg::ACT_LOAD && w_in_range && w_nonzero) begin
            w_claim_we = 1'b1;
        end

        w_actual_we    = 1'b0;
        w_actual_waddr = r_addr;
        w_actual_wdata = '0;
        if (r_state == S_CLEAR || r_state == S_SWEEP) begin
            w_actual_we = 1'b1;
        end else if (r_state == S_RMW) begin
            w_actual_we    = 1'b1;
            w_actual_waddr = r_part[IDX_W-1:0];
            w_actual_wdata = w_count_inc;
        end

        w_rd_addr = (r_state == S_SWEEP) ? r_addr : w_in_idx;
    end

    // Memories. The sweep reads an entry and writes it back as zero in the same cycle; the
    // read returns the old contents.
    always_ff @(posedge i_clk) begin
        if (w_claim_we) begin
            claim_mem[w_claim_waddr] <= w_claim_wdata;
        end
        r_claim_rd <= claim_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_actual_we) begin
            actual_mem[w_actual_waddr] <= w_actual_wdata;
        end
        r_actual_rd <= actual_mem[w_rd_addr];
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_valid_flag <= 1'b1;
            r_pend       <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_pend <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + IDX_W'(1);
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_owner     <= i_partition;
                        r_part      <= i_partition;
                        r_mism_out  <= '0;
                        r_first_out <= '0;
                        r_all_valid <= r_valid_flag;
                        case (i_action)
                            smcc_pkg::ACT_LOAD: begin
                                r_done   <= 1'b1;
                                r_status <= smcc_pkg::STAT_LOADED;
                            end
                            smcc_pkg::ACT_SLICE: begin
                                if (!w_nonzero) begin
                                    r_done   <= 1'b1;
                                    r_status <= smcc_pkg::STAT_FREE;
                                end else if (!w_in_range) begin
                                    r_done       <= 1'b1;
                                    r_status     <= smcc_pkg::STAT_RANGE;
                                    r_all_valid  <= 1'b0;
                                    r_valid_flag <= 1'b0;
                                end else begin
                                    r_state <= S_RMW;
                                end
                            end
                            smcc_pkg::ACT_FINISH: begin
                                r_state <= S_SWEEP;
                                r_addr  <= IDX_W'(1);
                                r_mism  <= '0;
                                r_first <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RMW: begin
                    r_done <= 1'b1;
                    if (w_unalloc) begin
                        r_status     <= smcc_pkg::STAT_UNALLOC;
                        r_all_valid  <= 1'b0;
                        r_valid_flag <= 1'b0;
                    end else begin
                        r_status <= smcc_pkg::STAT_COUNTED;
                    end
                    r_state <= S_IDLE;
                end
                S_SWEEP: begin
                    r_mism     <= n_mism;
                    r_first    <= n_first;
                    r_pend     <= 1'b1;
                    r_pend_idx <= r_addr;
                    r_addr     <= r_addr + IDX_W'(1);
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // The last partition's compare folds straight into the report.
                    r_done       <= 1'b1;
                    r_status     <= smcc_pkg::STAT_REPORT;
                    r_owner      <= '0;
                    r_mism_out   <= n_mism;
                    r_first_out  <= n_first;
                    r_all_valid  <= r_valid_flag && (n_mism == '0);
                    r_valid_flag <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_owner          = r_owner;
    assign o_mismatch_count = r_mism_out;
    assign o_first_mismatch = r_first_out;
    assign o_all_valid      = r_all_valid;

    // No result is produced while the memories are being cleared after reset.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_done)
        else $error("result strobe during clearing pass");

    // A slice naming an in-range nonzero owner goes through the read-modify-write state.
    a_slice_to_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == smcc_pkg::ACT_SLICE && w_in_range && w_nonzero)
        |=> (r_state == S_RMW))
        else $error("counted slice did not enter read-modify-write");

    // The read-modify-write cycle always ends in a counted or unallocated result.
    a_rmw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |=> (r_done && (o_status == smcc_pkg::STAT_COUNTED ||
                                           o_status == smcc_pkg::STAT_UNALLOC)))
        else $error("read-modify-write produced no count result");

    // A report can only claim validity when no mismatch was found.
    a_report_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && o_status == smcc_pkg::STAT_REPORT && o_all_valid)
        |-> (o_mismatch_count == '0 && o_first_mismatch == '0))
        else $error("report valid despite mismatches");

endmodule

// ===== test/tb_slice_map_consistency_check.sv =====
// Self-checking testbench for the slice map consistency checker.
// Holds a scoreboard class with its own model of the claim and slice tables,
// and the top module that drives the block. Depends on smcc_pkg and the RTL.
`timescale 1ns / 100ps

typedef struct packed {
    logic [smcc_pkg::STATUS_W-1:0] status;
    logic [smcc_pkg::PART_W-1:0]   owner;
    logic [smcc_pkg::MISM_W-1:0]   mism;
    logic [smcc_pkg::MISM_W-1:0]   first;
    logic                          ok;
} t_slice_outcome;

class slice_ledger #(int NPART = 1024);
    localparam int MISM_MAX = (1 << smcc_pkg::MISM_W) - 1;

    bit [smcc_pkg::COUNT_W-1:0] claim_tab [NPART];
    bit [smcc_pkg::COUNT_W-1:0] slice_tab [NPART];
    bit                         ok_flag;
    t_slice_outcome             outcome_q [$];

    int errors;
    int transfers;
    int reports;
    int clean_reports;
    int counted;
    int out_of_range;
    int unallocated;

    function new();
        ok_flag = 1'b1;
    endfunction

    function int pending();
        return outcome_q.size();
    endfunction

    // Updates the model for one accepted input transfer and queues its result.
    function void note_input(logic [smcc_pkg::ACTION_W-1:0] act,
                             logic [smcc_pkg::PART_W-1:0] part,
                             logic [smcc_pkg::COUNT_W-1:0] claim);
        t_slice_outcome exp;
        int unsigned    bad;
        int unsigned    first_bad;
        exp = '0;
        exp.owner = part;
        transfers++;
        case (act)
            smcc_pkg::ACT_LOAD: begin
                if (part != 0 && part < NPART)
                    claim_tab[part] = claim;
                exp.status = smcc_pkg::STAT_LOADED;
            end
            smcc_pkg::ACT_SLICE: begin
                if (part == 0) begin
                    exp.status = smcc_pkg::STAT_FREE;
                end else if (part >= NPART) begin
                    exp.status = smcc_pkg::STAT_RANGE;
                    ok_flag = 1'b0;
                    out_of_range++;
                end else begin
                    if (claim_tab[part] == 0) begin
                        exp.status = smcc_pkg::STAT_UNALLOC;
                        ok_flag = 1'b0;
                        unallocated++;
                    end else begin
                        exp.status = smcc_pkg::STAT_COUNTED;
                        counted++;
                    end
                    if (slice_tab[part] != '1)
                        slice_tab[part]++;
                end
            end
            smcc_pkg::ACT_FINISH: begin
                bad = 0;
                first_bad = 0;
                for (int i = 1; i < NPART; i++) begin
                    if (claim_tab[i] != 0 && claim_tab[i] != slice_tab[i]) begin
                        if (bad == 0)
                            first_bad = i;
                        if (bad < MISM_MAX)
                            bad++;
                    end
                end
                exp.status = smcc_pkg::STAT_REPORT;
                exp.owner = '0;
                exp.mism = smcc_pkg::MISM_W'(bad);
                exp.first = smcc_pkg::MISM_W'(first_bad);
                ok_flag = ok_flag && (bad == 0);
                reports++;
                if (ok_flag)
                    clean_reports++;
                foreach (slice_tab[i])
                    slice_tab[i] = '0;
            end
            default: begin
                return;
            end
        endcase
        exp.ok = ok_flag;
        if (act == smcc_pkg::ACT_FINISH)
            ok_flag = 1'b1;
        outcome_q = {outcome_q, exp};
    endfunction

    task report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(t_slice_outcome got);
        t_slice_outcome exp;
        if (outcome_q.size() == 0) begin
            report_mismatch("result with no transfer outstanding", got.status, 0);
            return;
        end
        exp = outcome_q.pop_front();
        if (got.status !== exp.status)
            report_mismatch("status", got.status, exp.status);
        if (got.owner !== exp.owner)
            report_mismatch("owner", got.owner, exp.owner);
        if (got.mism !== exp.mism)
            report_mismatch("mismatch_count", got.mism, exp.mism);
        if (got.first !== exp.first)
            report_mismatch("first_mismatch", got.first, exp.first);
        if (got.ok !== exp.ok)
            report_mismatch("all_valid", got.ok, exp.ok);
    endtask

    task flush_leftover();
        while (outcome_q.size() != 0) begin
            report_mismatch("expected result never arrived, status",
                            outcome_q[0].status, outcome_q[0].status);
            void'(outcome_q.pop_front());
        end
    endtask
endclass

module tb_slice_map_consistency_check;

    localparam int NPART          = smcc_pkg::NUM_PARTITIONS_DEF;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int ITEM_TARGET    = 400;
    localparam int MAX_GAP        = 16;
    // The longest quiet stretch in a correct run is the clearing pass after
    // reset or a full sweep plus a sender gap; the limit is several times that.
    localparam int WATCHDOG_LIMIT = 8 * NPART + 64;
    // The fourth action code is unused by the block and must be ignored.
    localparam logic [smcc_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          start           = 1'b0;
    logic [smcc_pkg::ACTION_W-1:0] i_action        = '0;
    logic [smcc_pkg::PART_W-1:0]   i_partition     = '0;
    logic [smcc_pkg::COUNT_W-1:0]  i_claimed_count = '0;
    logic                          busy;
    logic                          o_done;
    logic [smcc_pkg::STATUS_W-1:0] o_status;
    logic [smcc_pkg::PART_W-1:0]   o_owner;
    logic [smcc_pkg::MISM_W-1:0]   o_mismatch_count;
    logic [smcc_pkg::MISM_W-1:0]   o_first_mismatch;
    logic                          o_all_valid;

    slice_ledger #(NPART) ledger;
    int                   items_sent;
    int                   idle_cycles = 0;

    slice_map_consistency_check #(
        .NUM_PARTITIONS(NPART)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_partition     (i_partition),
        .i_claimed_count (i_claimed_count),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_owner         (o_owner),
        .o_mismatch_count(o_mismatch_count),
        .o_first_mismatch(o_first_mismatch),
        .o_all_valid     (o_all_valid)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Results cannot be held off, so every cycle with the strobe high is one
    // transfer. The outputs are read right after the edge, before any
    // nonblocking update of that edge lands, so they are the values that the
    // edge itself captured.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            ledger.check_result({o_status, o_owner, o_mismatch_count,
                                 o_first_mismatch, o_all_valid});
    end

    // Watchdog: any transfer in either direction restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap(bit no_idle);
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Presents one item and returns at the edge where it is transferred. Start
    // stays high on return so that a back-to-back item needs no second
    // assignment to it in the same time step; a nonzero gap lowers it first.
    task automatic send_item(input logic [smcc_pkg::ACTION_W-1:0] act,
                             input logic [smcc_pkg::PART_W-1:0] part,
                             input logic [smcc_pkg::COUNT_W-1:0] claim, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_action        <= act;
        i_partition     <= part;
        i_claimed_count <= claim;
        do @(posedge i_clk); while (busy !== 1'b0);
        ledger.note_input(act, part, claim);
        if (act != ACT_NONE)
            items_sent++;
    endtask

    // Holds the sender off until every outstanding result has come back. At
    // least one edge passes, so start is never lowered and raised in one step.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
    endtask

    // Deallocates every partition that currently holds a claim.
    task automatic clear_claims(bit no_idle);
        for (int i = 1; i < NPART; i++) begin
            if (ledger.claim_tab[i] != 0)
                send_item(smcc_pkg::ACT_LOAD, smcc_pkg::PART_W'(i), '0, pick_gap(no_idle));
        end
    endtask

    // A well-formed check: a fresh set of small claims, exactly the slices
    // they claim in random order mixed with free slices, then a report. When
    // spoiled, one slice is dropped or one is added.
    task automatic consistent_round(bit no_idle, bit spoil);
        logic [smcc_pkg::PART_W-1:0] parts [$];
        logic [smcc_pkg::PART_W-1:0] slices [$];
        logic [smcc_pkg::PART_W-1:0] tmp;
        bit                          taken [int];
        int                          k;
        int                          j;
        int                          p;
        clear_claims(no_idle);
        k = $urandom_range(1, 6);
        repeat (k) begin
            p = $urandom_range(1, NPART - 1);
            send_item(smcc_pkg::ACT_LOAD, smcc_pkg::PART_W'(p),
                      smcc_pkg::COUNT_W'($urandom_range(1, 3)), pick_gap(no_idle));
            if (!taken.exists(p)) begin
                taken[p] = 1'b1;
                parts = {parts, smcc_pkg::PART_W'(p)};
            end
        end
        foreach (parts[i])
            repeat (ledger.claim_tab[parts[i]]) slices = {slices, parts[i]};
        repeat ($urandom_range(0, 3)) slices = {slices, smcc_pkg::PART_W'(0)};
        if (spoil) begin
            if ($urandom_range(0, 1) == 0)
                void'(slices.pop_back());
            else
                slices = {slices, parts[0]};
        end
        for (int i = slices.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = slices[i];
            slices[i] = slices[j];
            slices[j] = tmp;
        end
        foreach (slices[i])
            send_item(smcc_pkg::ACT_SLICE, slices[i], $urandom, pick_gap(no_idle));
        if ($urandom_range(0, 4) == 0)
            drain_results();
        send_item(smcc_pkg::ACT_FINISH, smcc_pkg::PART_W'($urandom), $urandom,
                  pick_gap(no_idle));
    endtask

    // Random mix of loads, slices and ignored actions over the whole field
    // ranges, closed by a report.
    task automatic noise_round(bit no_idle);
        logic [smcc_pkg::ACTION_W-1:0] act;
        logic [smcc_pkg::PART_W-1:0]   part;
        logic [smcc_pkg::COUNT_W-1:0]  claim;
        int                            n;
        int                            r;
        n = $urandom_range(4, 20);
        repeat (n) begin
            r = $urandom_range(0, 9);
            act = (r < 3) ? smcc_pkg::ACT_LOAD : (r < 9) ? smcc_pkg::ACT_SLICE : ACT_NONE;
            case ($urandom_range(0, 3))
                0: part = smcc_pkg::PART_W'($urandom);
                1: part = '0;
                default: part = smcc_pkg::PART_W'($urandom_range(1, NPART - 1));
            endcase
            claim = ($urandom_range(0, 1) == 0) ? smcc_pkg::COUNT_W'($urandom) :
                                                  smcc_pkg::COUNT_W'($urandom_range(0, 4));
            send_item(act, part, claim, pick_gap(no_idle));
        end
        send_item(smcc_pkg::ACT_FINISH, smcc_pkg::PART_W'($urandom), $urandom,
                  pick_gap(no_idle));
    endtask

    initial begin
        ledger = new();
        items_sent = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items, back to back. Loads to index zero and beyond the
        // table store nothing; slices cover free, out-of-range, counted and
        // unallocated owners; the unused action code must give no result.
        send_item(smcc_pkg::ACT_LOAD, 16'd1, 32'hFFFF_FFFF, 0);
        send_item(smcc_pkg::ACT_LOAD, smcc_pkg::PART_W'(NPART - 1), 32'd1, 0);
        send_item(smcc_pkg::ACT_LOAD, '0, 32'h5A5A_5A5A, 0);
        send_item(smcc_pkg::ACT_LOAD, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_item(smcc_pkg::ACT_LOAD, smcc_pkg::PART_W'(NPART), 32'd7, 0);
        send_item(smcc_pkg::ACT_SLICE, '0, '0, 0);
        send_item(smcc_pkg::ACT_SLICE, 16'hFFFF, '0, 0);
        send_item(smcc_pkg::ACT_SLICE, smcc_pkg::PART_W'(NPART), '0, 0);
        send_item(smcc_pkg::ACT_SLICE, smcc_pkg::PART_W'(NPART - 1), 32'hFFFF_FFFF, 0);
        send_item(smcc_pkg::ACT_SLICE, 16'd5, '0, 0);
        send_item(ACT_NONE, 16'd1, 32'hFFFF_FFFF, 0);
        send_item(smcc_pkg::ACT_FINISH, '0, '0, 0);
        // A second report sees cleared counts and a restored valid flag, but
        // the claims are kept, so both partitions now mismatch.
        send_item(smcc_pkg::ACT_FINISH, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_item(smcc_pkg::ACT_LOAD, 16'd1, '0, 0);
        send_item(smcc_pkg::ACT_FINISH, '0, '0, 0);
        send_item(smcc_pkg::ACT_LOAD, smcc_pkg::PART_W'(NPART - 1), '0, 0);
        send_item(smcc_pkg::ACT_FINISH, '0, '0, 0);
        // A partition that lost its claim is unallocated again.
        send_item(smcc_pkg::ACT_SLICE, smcc_pkg::PART_W'(NPART - 1), '0, 0);
        send_item(smcc_pkg::ACT_FINISH, '0, '0, 0);
        send_item(smcc_pkg::ACT_LOAD, 16'd2, 32'd2, 0);
        send_item(smcc_pkg::ACT_SLICE, 16'd2, '0, 0);
        send_item(smcc_pkg::ACT_SLICE, 16'd2, '0, 0);
        send_item(smcc_pkg::ACT_FINISH, '0, '0, 0);

        // The sender holds off here until all results are back.
        drain_results();

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 2) != 0)
                consistent_round($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            else
                noise_round($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                drain_results();
        end

        drain_results();
        // A sweep is the longest thing the block does; a stray result would
        // show up well within this wait.
        repeat (NPART + 16) @(posedge i_clk);
        ledger.flush_leftover();

        $display("Run covered %0d input transfers and %0d reports, %0d of them consistent.",
                 ledger.transfers, ledger.reports, ledger.clean_reports);
        $display("Slices: %0d counted, %0d with owner out of range, %0d unallocated.",
                 ledger.counted, ledger.out_of_range, ledger.unallocated);
        if (ledger.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
